// File: hw/rtl/tie_pkg.sv
// ----------------------------------------------------------------------------
// tie_pkg
// Shared types and constants for the Tomasulo issue engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tie_pkg;

    localparam int LAT_W   = 6;
    localparam int NUM_CFG = 5;

    // opcodes
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_ADDI = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_ADD_LAT  = 3'd0;
    localparam logic [2:0] CFG_SUB_LAT  = 3'd1;
    localparam logic [2:0] CFG_ADDI_LAT = 3'd2;
    localparam logic [2:0] CFG_MUL_LAT  = 3'd3;
    localparam logic [2:0] CFG_DIV_LAT  = 3'd4;

    localparam logic [LAT_W-1:0] RST_ADD_LAT  = 6'd2;
    localparam logic [LAT_W-1:0] RST_SUB_LAT  = 6'd2;
    localparam logic [LAT_W-1:0] RST_ADDI_LAT = 6'd2;
    localparam logic [LAT_W-1:0] RST_MUL_LAT  = 6'd10;
    localparam logic [LAT_W-1:0] RST_DIV_LAT  = 6'd20;

    typedef struct packed {
        logic               action;
        logic [2:0]         opcode;
        logic [2:0]         dest_reg;
        logic [2:0]         src1_reg;
        logic [2:0]         src2_reg;
        logic signed [31:0] immediate;
    } in_t;

    typedef struct packed {
        logic               issue_accepted;
        logic               add_wb_valid;
        logic [2:0]         add_wb_reg;
        logic signed [31:0] add_wb_value;
        logic               mul_wb_valid;
        logic [2:0]         mul_wb_reg;
        logic signed [31:0] mul_wb_value;
        logic               all_idle;
    } out_t;

    typedef struct packed {
        logic latch;
        logic wb;
        logic disp;
        logic exec;
        logic rd1;
        logic rd2;
        logic issue;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic need_md;
        logic md_done;
    } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/tie_muldiv.sv
// ----------------------------------------------------------------------------
// tie_muldiv
// Iterative multiply / signed divide, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tie_muldiv #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  is_div,
    input  wire logic [DATA_WIDTH-1:0] op_a,
    input  wire logic [DATA_WIDTH-1:0] op_b,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      result
);

    localparam int DW = DATA_WIDTH;
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          div_reg, neg_reg, bzero_reg;
    logic [DW-1:0] x_reg, y_reg, acc_reg, result_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW:0]   sh;
    logic          qbit;
    logic [DW-1:0] mag_a, mag_b;

    assign mag_a = op_a[DW-1] ? DW'(-op_a) : op_a;
    assign mag_b = op_b[DW-1] ? DW'(-op_b) : op_b;
    assign sh    = {acc_reg, y_reg[DW-1]};
    assign qbit  = (sh >= {1'b0, x_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg   <= is_div;
            neg_reg   <= op_a[DW-1] ^ op_b[DW-1];
            bzero_reg <= (op_b == '0);
            acc_reg   <= '0;
            x_reg     <= is_div ? mag_b : op_a;
            y_reg     <= is_div ? mag_a : op_b;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (div_reg)
            begin
                acc_reg <= qbit ? DW'(sh - {1'b0, x_reg}) : DW'(sh);
                y_reg   <= {y_reg[DW-2:0], qbit};
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_reg <= acc_reg + x_reg;
                end
                x_reg <= {x_reg[DW-2:0], 1'b0};
                y_reg <= {1'b0, y_reg[DW-1:1]};
            end
        end
        else if (busy_reg)
        begin
            if (!div_reg)
            begin
                result_reg <= acc_reg;
            end
            else if (bzero_reg)
            begin
                result_reg <= '0;
            end
            else
            begin
                result_reg <= neg_reg ? DW'(-y_reg) : y_reg;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tie_datapath.sv
// ----------------------------------------------------------------------------
// tie_datapath
// Register file, rename table, reservation stations and execution units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tie_datapath #(
    parameter int ADD_STATIONS = 3,
    parameter int MUL_STATIONS = 2,
    parameter int REG_COUNT    = 5,
    parameter int DATA_WIDTH   = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire tie_pkg::cmd_t             cmd,
    output tie_pkg::sts_t                  sts,
    input  wire tie_pkg::in_t              in_word,
    input  wire logic                      cfg_we,
    input  wire logic [2:0]                cfg_index,
    input  wire logic [tie_pkg::LAT_W-1:0] cfg_data,
    output tie_pkg::out_t                  out_word
);

    localparam int NS = ADD_STATIONS + MUL_STATIONS;
    localparam int TW = (NS > 1) ? $clog2(NS) : 1;
    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int DW = DATA_WIDTH;
    localparam int LW = tie_pkg::LAT_W;

    // configuration
    logic [LW-1:0] lat_reg [tie_pkg::NUM_CFG];

    // architectural state
    logic [DW-1:0] rf_reg       [REG_COUNT];
    logic [TW-1:0] ren_tag_reg  [REG_COUNT];
    logic [REG_COUNT-1:0] ren_pend_reg;

    // stations
    logic [NS-1:0] st_busy_reg, st_disp_reg, st_w1_reg, st_w2_reg;
    logic [TW-1:0] st_t1_reg [NS];
    logic [TW-1:0] st_t2_reg [NS];
    logic [2:0]    st_op_reg   [NS];
    logic [2:0]    st_dest_reg [NS];
    logic [DW-1:0] st_v1_reg   [NS];
    logic [DW-1:0] st_v2_reg   [NS];

    // units
    logic [1:0]    unit_busy_reg, unit_new_reg;
    logic [TW-1:0] unit_st_reg  [2];
    logic [LW-1:0] unit_cnt_reg [2];
    logic [DW-1:0] unit0_res_reg;

    // per-word scratch
    tie_pkg::in_t  in_reg;
    logic [1:0]    wb_valid_reg;
    logic [2:0]    wb_dest_reg [2];
    logic [DW-1:0] wb_val_reg  [2];
    logic          acc_reg;
    logic [DW-1:0] rd1_val_reg, rd2_val_reg;
    logic          rd1_pend_reg, rd2_pend_reg;
    logic [TW-1:0] rd1_tag_reg, rd2_tag_reg;
    tie_pkg::out_t out_reg;

    // multiply / divide unit
    logic          md_start, md_done;
    logic [DW-1:0] md_result;

    // writeback
    logic [1:0]    fin, fin_hit;
    logic [TW-1:0] fin_st  [2];
    logic [DW-1:0] fin_res [2];
    logic [2:0]    fin_dest[2];

    always_comb
    begin
        for (int u = 0; u < 2; u++)
        begin
            fin[u]      = unit_busy_reg[u] && (unit_cnt_reg[u] <= LW'(1));
            fin_st[u]   = unit_st_reg[u];
            fin_dest[u] = st_dest_reg[fin_st[u]];
            fin_hit[u]  = fin[u] && ren_pend_reg[RW'(fin_dest[u])]
                          && (ren_tag_reg[RW'(fin_dest[u])] == fin_st[u]);
        end
        fin_res[0] = unit0_res_reg;
        fin_res[1] = md_result;
    end

    // dispatch selection, lowest-numbered ready station per unit
    logic [NS-1:0] ready;
    logic [1:0]    d_found;
    logic [TW-1:0] d_sel [2];
    logic [LW-1:0] d_lat [2];

    always_comb
    begin
        ready      = st_busy_reg & ~st_disp_reg & ~st_w1_reg & ~st_w2_reg;
        d_found    = '0;
        d_sel[0]   = '0;
        d_sel[1]   = '0;
        for (int k = ADD_STATIONS - 1; k >= 0; k--)
        begin
            if (ready[k])
            begin
                d_found[0] = 1'b1;
                d_sel[0]   = TW'(k);
            end
        end
        for (int k = NS - 1; k >= ADD_STATIONS; k--)
        begin
            if (ready[k])
            begin
                d_found[1] = 1'b1;
                d_sel[1]   = TW'(k);
            end
        end
        for (int u = 0; u < 2; u++)
        begin
            case (st_op_reg[d_sel[u]])
                tie_pkg::OP_SUB:  d_lat[u] = lat_reg[tie_pkg::CFG_SUB_LAT];
                tie_pkg::OP_ADDI: d_lat[u] = lat_reg[tie_pkg::CFG_ADDI_LAT];
                tie_pkg::OP_MUL:  d_lat[u] = lat_reg[tie_pkg::CFG_MUL_LAT];
                tie_pkg::OP_DIV:  d_lat[u] = lat_reg[tie_pkg::CFG_DIV_LAT];
                default:          d_lat[u] = lat_reg[tie_pkg::CFG_ADD_LAT];
            endcase
            if (d_lat[u] == '0)
            begin
                d_lat[u] = LW'(1);
            end
        end
    end

    // operand read, one register index per cycle
    logic [2:0]    rd_src;
    logic [RW-1:0] rd_idx;
    logic          rd_in;
    logic [DW-1:0] rd_val;
    logic          rd_pend;
    logic [TW-1:0] rd_tag;

    always_comb
    begin
        rd_src  = cmd.rd1 ? in_reg.src1_reg : in_reg.src2_reg;
        rd_idx  = RW'(rd_src);
        rd_in   = int'(rd_src) < REG_COUNT;
        rd_val  = rd_in ? rf_reg[rd_idx] : '0;
        rd_pend = rd_in ? ren_pend_reg[rd_idx] : 1'b0;
        rd_tag  = rd_in ? ren_tag_reg[rd_idx] : '0;
    end

    // issue selection
    logic          is_ok, is_mul, is_found;
    logic [TW-1:0] is_sel;
    logic [RW-1:0] is_dest;
    logic [DW-1:0] imm_ext;

    always_comb
    begin
        is_ok = in_reg.action && (in_reg.opcode <= tie_pkg::OP_DIV)
                && (int'(in_reg.dest_reg) < REG_COUNT)
                && (int'(in_reg.src1_reg) < REG_COUNT)
                && ((in_reg.opcode == tie_pkg::OP_ADDI)
                    || (int'(in_reg.src2_reg) < REG_COUNT));
        is_mul   = (in_reg.opcode >= tie_pkg::OP_MUL);
        is_found = 1'b0;
        is_sel   = '0;
        for (int k = NS - 1; k >= 0; k--)
        begin
            if (!st_busy_reg[k] && ((k >= ADD_STATIONS) == is_mul))
            begin
                is_found = is_ok;
                is_sel   = TW'(k);
            end
        end
        is_dest = RW'(in_reg.dest_reg);
        imm_ext = DW'(in_reg.immediate);
    end

    // unit 0 operands at execute
    logic [DW-1:0] e0_a, e0_b;
    assign e0_a = st_v1_reg[unit_st_reg[0]];
    assign e0_b = st_v2_reg[unit_st_reg[0]];

    assign md_start = cmd.exec && unit_new_reg[1];

    tie_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .is_div (st_op_reg[unit_st_reg[1]] == tie_pkg::OP_DIV),
        .op_a   (st_v1_reg[unit_st_reg[1]]),
        .op_b   (st_v2_reg[unit_st_reg[1]]),
        .done   (md_done),
        .result (md_result)
    );

    assign sts.need_md = unit_new_reg[1];
    assign sts.md_done = md_done;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg[tie_pkg::CFG_ADD_LAT]  <= tie_pkg::RST_ADD_LAT;
            lat_reg[tie_pkg::CFG_SUB_LAT]  <= tie_pkg::RST_SUB_LAT;
            lat_reg[tie_pkg::CFG_ADDI_LAT] <= tie_pkg::RST_ADDI_LAT;
            lat_reg[tie_pkg::CFG_MUL_LAT]  <= tie_pkg::RST_MUL_LAT;
            lat_reg[tie_pkg::CFG_DIV_LAT]  <= tie_pkg::RST_DIV_LAT;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i]      <= DW'(2 * i);
                ren_tag_reg[i] <= '0;
            end
            ren_pend_reg  <= '0;
            st_busy_reg   <= '0;
            st_disp_reg   <= '0;
            st_w1_reg     <= '0;
            st_w2_reg     <= '0;
            unit_busy_reg <= '0;
            unit_new_reg  <= '0;
            for (int u = 0; u < 2; u++)
            begin
                unit_st_reg[u]  <= '0;
                unit_cnt_reg[u] <= '0;
            end
        end
        else
        begin
            if (cfg_we && int'(cfg_index) < tie_pkg::NUM_CFG)
            begin
                lat_reg[cfg_index] <= cfg_data;
            end
            if (cmd.wb)
            begin
                for (int u = 0; u < 2; u++)
                begin
                    if (unit_busy_reg[u] && !fin[u])
                    begin
                        unit_cnt_reg[u] <= unit_cnt_reg[u] - 1'b1;
                    end
                    if (fin[u])
                    begin
                        unit_busy_reg[u]      <= 1'b0;
                        st_busy_reg[fin_st[u]] <= 1'b0;
                        st_disp_reg[fin_st[u]] <= 1'b0;
                    end
                    if (fin_hit[u])
                    begin
                        rf_reg[RW'(fin_dest[u])]       <= fin_res[u];
                        ren_pend_reg[RW'(fin_dest[u])] <= 1'b0;
                    end
                end
                // tag broadcast
                for (int k = 0; k < NS; k++)
                begin
                    for (int u = 0; u < 2; u++)
                    begin
                        if (fin[u] && st_busy_reg[k] && st_w1_reg[k]
                            && st_t1_reg[k] == fin_st[u])
                        begin
                            st_w1_reg[k] <= 1'b0;
                        end
                        if (fin[u] && st_busy_reg[k] && st_w2_reg[k]
                            && st_t2_reg[k] == fin_st[u])
                        begin
                            st_w2_reg[k] <= 1'b0;
                        end
                    end
                end
            end
            if (cmd.disp)
            begin
                for (int u = 0; u < 2; u++)
                begin
                    unit_new_reg[u] <= !unit_busy_reg[u] && d_found[u];
                    if (!unit_busy_reg[u] && d_found[u])
                    begin
                        st_disp_reg[d_sel[u]] <= 1'b1;
                        unit_busy_reg[u]      <= 1'b1;
                        unit_st_reg[u]        <= d_sel[u];
                        unit_cnt_reg[u]       <= d_lat[u];
                    end
                end
            end
            if (cmd.issue && is_found)
            begin
                st_busy_reg[is_sel]   <= 1'b1;
                st_disp_reg[is_sel]   <= 1'b0;
                st_w1_reg[is_sel]     <= rd1_pend_reg;
                st_w2_reg[is_sel]     <= (in_reg.opcode != tie_pkg::OP_ADDI) && rd2_pend_reg;
                ren_tag_reg[is_dest]  <= is_sel;
                ren_pend_reg[is_dest] <= 1'b1;
            end
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            in_reg <= in_word;
        end
        if (cmd.wb)
        begin
            for (int u = 0; u < 2; u++)
            begin
                wb_valid_reg[u] <= fin[u];
                wb_dest_reg[u]  <= fin[u] ? fin_dest[u] : 3'd0;
                wb_val_reg[u]   <= fin[u] ? fin_res[u] : '0;
            end
            for (int k = 0; k < NS; k++)
            begin
                for (int u = 0; u < 2; u++)
                begin
                    if (fin[u] && st_busy_reg[k] && st_w1_reg[k]
                        && st_t1_reg[k] == fin_st[u])
                    begin
                        st_v1_reg[k] <= fin_res[u];
                    end
                    if (fin[u] && st_busy_reg[k] && st_w2_reg[k]
                        && st_t2_reg[k] == fin_st[u])
                    begin
                        st_v2_reg[k] <= fin_res[u];
                    end
                end
            end
        end
        if (cmd.exec && unit_new_reg[0])
        begin
            unit0_res_reg <= (st_op_reg[unit_st_reg[0]] == tie_pkg::OP_SUB)
                             ? e0_a - e0_b : e0_a + e0_b;
        end
        if (cmd.rd1)
        begin
            rd1_val_reg  <= rd_val;
            rd1_pend_reg <= rd_pend;
            rd1_tag_reg  <= rd_tag;
        end
        if (cmd.rd2)
        begin
            rd2_val_reg  <= rd_val;
            rd2_pend_reg <= rd_pend;
            rd2_tag_reg  <= rd_tag;
        end
        if (cmd.issue)
        begin
            acc_reg <= is_found;
            if (is_found)
            begin
                st_op_reg[is_sel]   <= in_reg.opcode;
                st_dest_reg[is_sel] <= in_reg.dest_reg;
                st_t1_reg[is_sel]   <= rd1_tag_reg;
                st_v1_reg[is_sel]   <= rd1_pend_reg ? '0 : rd1_val_reg;
                st_t2_reg[is_sel]   <= rd2_tag_reg;
                if (in_reg.opcode == tie_pkg::OP_ADDI)
                begin
                    st_v2_reg[is_sel] <= imm_ext;
                end
                else
                begin
                    st_v2_reg[is_sel] <= rd2_pend_reg ? '0 : rd2_val_reg;
                end
            end
        end
        if (cmd.fin)
        begin
            out_reg.issue_accepted <= acc_reg;
            out_reg.add_wb_valid   <= wb_valid_reg[0];
            out_reg.add_wb_reg     <= wb_dest_reg[0];
            out_reg.add_wb_value   <= 32'(wb_val_reg[0]);
            out_reg.mul_wb_valid   <= wb_valid_reg[1];
            out_reg.mul_wb_reg     <= wb_dest_reg[1];
            out_reg.mul_wb_value   <= 32'(wb_val_reg[1]);
            out_reg.all_idle       <= !(|st_busy_reg) && !(|ren_pend_reg);
        end
    end

    assign out_word = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tie_ctrl.sv
// ----------------------------------------------------------------------------
// tie_ctrl
// Sequencer: steps the datapath through the phases of one tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tie_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire tie_pkg::sts_t sts,
    output tie_pkg::cmd_t      cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WB    = 9'b000000010,
        S_DISP  = 9'b000000100,
        S_EXEC  = 9'b000001000,
        S_MDW   = 9'b000010000,
        S_RD1   = 9'b000100000,
        S_RD2   = 9'b001000000,
        S_ISSUE = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                cmd.latch = accept;
                if (accept)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                cmd.wb     = 1'b1;
                state_next = S_DISP;
            end
            S_DISP:
            begin
                cmd.disp   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.need_md ? S_MDW : S_RD1;
            end
            S_MDW:
            begin
                if (sts.md_done)
                begin
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                cmd.rd1    = 1'b1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // wait here while the previous word is still held
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.fin     = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tomasulo_issue_engine.sv
// ----------------------------------------------------------------------------
// tomasulo_issue_engine
// Tomasulo scheduler with reservation stations, renaming and two units.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word is one machine tick, optionally offering an instruction.
//   in_valid/in_stall and out_valid/out_stall move words; one output word per
//   input word. cfg_valid/cfg_ready write latency registers (ready is always
//   high); write them only while the block is idle.
//   Steps: each accepted word passes write-back, dispatch and execute, then
//   waits for the bit-serial multiply/divide unit when it was started that
//   tick, then reads both sources, issues and registers the output word.
//   A new word is taken only once the last has finished its steps; it can be
//   taken while the previous output word is still waiting.
//   Reset: register file holds 0,2,4,..., all stations and units free,
//   latencies at their defaults.
//   A stalled output word holds steady; the following word runs up to its
//   last step and waits there until the held word is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tomasulo_issue_engine #(
    parameter int ADD_STATIONS = 3,
    parameter int MUL_STATIONS = 2,
    parameter int REG_COUNT    = 5,
    parameter int DATA_WIDTH   = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire tie_pkg::in_t              in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output tie_pkg::out_t                  out_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [2:0]                cfg_index,
    input  wire logic [tie_pkg::LAT_W-1:0] cfg_data
);

    tie_pkg::cmd_t cmd;
    tie_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    tie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tie_datapath #(
        .ADD_STATIONS (ADD_STATIONS),
        .MUL_STATIONS (MUL_STATIONS),
        .REG_COUNT    (REG_COUNT),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_word   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_word  (out_data)
    );

endmodule

`default_nettype wire

// File: hw/rtl/tie_checker.sv
// ----------------------------------------------------------------------------
// tie_checker
// Port-level checks for the Tomasulo issue engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tie_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_stall,
    input wire logic          out_valid,
    input wire logic          out_stall,
    input wire tie_pkg::out_t out_data
);

    // an accepted tick is worked on before the next is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second word accepted while busy");

    a_idle_mul_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.mul_wb_valid) |->
        (out_data.mul_wb_reg == 3'd0 && out_data.mul_wb_value == 32'sd0))
        else $error("idle multiply writeback not zero");

    a_idle_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.add_wb_valid) |->
        (out_data.add_wb_reg == 3'd0 && out_data.add_wb_value == 32'sd0))
        else $error("idle adder writeback not zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled output word changed");

endmodule

bind tomasulo_issue_engine tie_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
